// ===== src/fst_pkg.sv =====
// shared constants and types for the foot swing trajectory unit
package fst_pkg;

  localparam int PHASE_FRAC_BITS_DEF = 16;
  localparam int COORD_WIDTH_DEF     = 20;
  localparam int STEP_WIDTH          = 17;

  // one load enable per pipeline stage, stage 5 is the output register
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pipe_en_t;

endpackage

// ===== src/fst_in_if.sv =====
// input channel of the foot swing trajectory unit
interface fst_in_if #(
  parameter int PHASE_FRAC_BITS = 16,
  parameter int COORD_WIDTH     = 20,
  parameter int STEP_WIDTH      = 17
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_WIDTH-1:0] liftoff_x;
  logic signed [COORD_WIDTH-1:0] liftoff_y;
  logic signed [COORD_WIDTH-1:0] liftoff_z;
  logic signed [COORD_WIDTH-1:0] touchdown_x;
  logic signed [COORD_WIDTH-1:0] touchdown_y;
  logic signed [COORD_WIDTH-1:0] touchdown_z;
  logic signed [PHASE_FRAC_BITS+1:0] stride_phase;
  logic signed [STEP_WIDTH-1:0]  step_height;

  modport source (
    output valid, liftoff_x, liftoff_y, liftoff_z,
    output touchdown_x, touchdown_y, touchdown_z, stride_phase, step_height,
    input  ready
  );
  modport sink (
    input  valid, liftoff_x, liftoff_y, liftoff_z,
    input  touchdown_x, touchdown_y, touchdown_z, stride_phase, step_height,
    output ready
  );
endinterface

// ===== src/fst_out_if.sv =====
// result channel of the foot swing trajectory unit
interface fst_out_if #(
  parameter int COORD_WIDTH = 20
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] foot_x;
  logic signed [COORD_WIDTH:0]   foot_y;
  logic signed [COORD_WIDTH-1:0] foot_z;

  modport source (output valid, foot_x, foot_y, foot_z, input ready);
  modport sink (input valid, foot_x, foot_y, foot_z, output ready);
endinterface

// ===== src/foot_swing_trajectory_unit.sv =====
// foot swing trajectory unit, top level
// throughput: one item per cycle unless the output stalls, set by the five-stage
//   pipeline with the multiplies of each of the three axis lanes in stages 2 to 4
//   (t*t, t2*(3-2t), delta*s)
// each stage holds its item while the next is full, so stalls back up stage by stage
// reset clears all stage valid bits; payload registers are not reset
module foot_swing_trajectory_unit import fst_pkg::*; #(
  parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF,
  parameter int COORD_WIDTH     = COORD_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  fst_in_if.sink    in_ch,
  fst_out_if.source out_ch
);
  localparam int PF = PHASE_FRAC_BITS;
  localparam int CW = COORD_WIDTH;
  localparam int AW = ((CW > STEP_WIDTH) ? CW : STEP_WIDTH) + 1;
  localparam int NS = 5;

  pipe_en_t            en;
  logic [NS-1:0]       v_r, v_nxt;

  logic [PF:0]         t_xz, t_y;
  logic signed [CW:0]  delta_x, delta_z;
  logic signed [AW:0]  delta_y;
  logic signed [CW-1:0] from_x, from_z;
  logic signed [AW-1:0] from_y;
  logic signed [CW-1:0] lane_x, lane_z;
  logic signed [AW-1:0] lane_y;

  always_comb begin
    en.s5 = !v_r[4] || out_ch.ready;
    en.s4 = !v_r[3] || en.s5;
    en.s3 = !v_r[2] || en.s4;
    en.s2 = !v_r[1] || en.s3;
    en.s1 = !v_r[0] || en.s2;
    v_nxt[0] = en.s1 ? in_ch.valid : v_r[0];
    v_nxt[1] = en.s2 ? v_r[0] : v_r[1];
    v_nxt[2] = en.s3 ? v_r[1] : v_r[2];
    v_nxt[3] = en.s4 ? v_r[2] : v_r[3];
    v_nxt[4] = en.s5 ? v_r[3] : v_r[4];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ch.ready  = en.s1;
  assign out_ch.valid = v_r[4];

  fst_prep #(
    .PHASE_FRAC_BITS(PF),
    .COORD_WIDTH    (CW),
    .APEX_WIDTH     (AW)
  ) u_prep (
    .clk         (clk),
    .en          (en),
    .liftoff_x   (in_ch.liftoff_x),
    .liftoff_y   (in_ch.liftoff_y),
    .liftoff_z   (in_ch.liftoff_z),
    .touchdown_x (in_ch.touchdown_x),
    .touchdown_y (in_ch.touchdown_y),
    .touchdown_z (in_ch.touchdown_z),
    .stride_phase(in_ch.stride_phase),
    .step_height (in_ch.step_height),
    .t_xz        (t_xz),
    .t_y         (t_y),
    .delta_x     (delta_x),
    .delta_z     (delta_z),
    .delta_y     (delta_y),
    .from_x      (from_x),
    .from_z      (from_z),
    .from_y      (from_y)
  );

  fst_lane #(.PHASE_FRAC_BITS(PF), .DELTA_WIDTH(CW + 1), .FROM_WIDTH(CW)) u_lane_x (
    .clk(clk), .en(en), .t(t_xz), .delta(delta_x), .from(from_x), .result(lane_x)
  );

  fst_lane #(.PHASE_FRAC_BITS(PF), .DELTA_WIDTH(AW + 1), .FROM_WIDTH(AW)) u_lane_y (
    .clk(clk), .en(en), .t(t_y), .delta(delta_y), .from(from_y), .result(lane_y)
  );

  fst_lane #(.PHASE_FRAC_BITS(PF), .DELTA_WIDTH(CW + 1), .FROM_WIDTH(CW)) u_lane_z (
    .clk(clk), .en(en), .t(t_xz), .delta(delta_z), .from(from_z), .result(lane_z)
  );

  fst_merge #(.COORD_WIDTH(CW), .APEX_WIDTH(AW)) u_merge (
    .clk   (clk),
    .en    (en),
    .lane_x(lane_x),
    .lane_y(lane_y),
    .lane_z(lane_z),
    .foot_x(out_ch.foot_x),
    .foot_y(out_ch.foot_y),
    .foot_z(out_ch.foot_z)
  );

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> (v_r == '0))
    else $error("pipeline not empty after reset");

  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (v_r == '1))
    else $error("input stalled with a free stage");

  a_item_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (en.s5 && v_r[3]) |=> out_ch.valid)
    else $error("item lost between last lane stage and output");

  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    (en.s5 && !v_r[3]) |=> !out_ch.valid)
    else $error("result appeared without an item");
endmodule

// ===== src/fst_prep.sv =====
// phase clamp, apex and per-axis delta setup, registered as stage 1
module fst_prep import fst_pkg::*; #(
  parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF,
  parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int APEX_WIDTH      = COORD_WIDTH_DEF + 1
) (
  input  logic                              clk,
  input  pipe_en_t                          en,
  input  logic signed [COORD_WIDTH-1:0]     liftoff_x,
  input  logic signed [COORD_WIDTH-1:0]     liftoff_y,
  input  logic signed [COORD_WIDTH-1:0]     liftoff_z,
  input  logic signed [COORD_WIDTH-1:0]     touchdown_x,
  input  logic signed [COORD_WIDTH-1:0]     touchdown_y,
  input  logic signed [COORD_WIDTH-1:0]     touchdown_z,
  input  logic signed [PHASE_FRAC_BITS+1:0] stride_phase,
  input  logic signed [STEP_WIDTH-1:0]      step_height,
  output logic [PHASE_FRAC_BITS:0]          t_xz,
  output logic [PHASE_FRAC_BITS:0]          t_y,
  output logic signed [COORD_WIDTH:0]       delta_x,
  output logic signed [COORD_WIDTH:0]       delta_z,
  output logic signed [APEX_WIDTH:0]        delta_y,
  output logic signed [COORD_WIDTH-1:0]     from_x,
  output logic signed [COORD_WIDTH-1:0]     from_z,
  output logic signed [APEX_WIDTH-1:0]      from_y
);
  localparam int PF = PHASE_FRAC_BITS;
  localparam int CW = COORD_WIDTH;
  localparam int AW = APEX_WIDTH;
  localparam int TW = PF + 1;
  localparam logic [TW-1:0] ONE  = TW'(1) << PF;
  localparam logic [TW-1:0] HALF = TW'(1) << (PF - 1);

  logic [TW-1:0]        p_c;
  logic [TW-1:0]        p_m;
  logic                 rising;
  logic [STEP_WIDTH-2:0] h_c;
  logic signed [CW-1:0] hi_c;
  logic signed [AW-1:0] apex;
  logic signed [AW-1:0] ly_a;
  logic signed [AW:0]   apex_e;
  logic signed [AW:0]   ly_e;
  logic signed [AW:0]   ty_e;
  logic signed [CW:0]   lx_e, lz_e, tx_e, tz_e;

  logic [TW-1:0]        t_xz_r, t_y_r;
  logic signed [CW:0]   dx_r, dz_r;
  logic signed [AW:0]   dy_r;
  logic signed [CW-1:0] fx_r, fz_r;
  logic signed [AW-1:0] fy_r;

  always_comb begin
    priority if (stride_phase[PF+1]) begin
      p_c = '0;
    end else if (stride_phase[PF:0] > ONE) begin
      p_c = ONE;
    end else begin
      p_c = stride_phase[PF:0];
    end
    rising = (p_c < HALF);
    p_m    = p_c - HALF;
    h_c    = step_height[STEP_WIDTH-1] ? '0 : step_height[STEP_WIDTH-2:0];
    hi_c   = (liftoff_y > touchdown_y) ? liftoff_y : touchdown_y;
    apex   = AW'(hi_c) + AW'({1'b0, h_c});
    ly_a   = AW'(liftoff_y);
    apex_e = (AW+1)'(apex);
    ly_e   = (AW+1)'(liftoff_y);
    ty_e   = (AW+1)'(touchdown_y);
    lx_e   = (CW+1)'(liftoff_x);
    lz_e   = (CW+1)'(liftoff_z);
    tx_e   = (CW+1)'(touchdown_x);
    tz_e   = (CW+1)'(touchdown_z);
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      t_xz_r <= p_c;
      t_y_r  <= rising ? {p_c[TW-2:0], 1'b0} : {p_m[TW-2:0], 1'b0};
      dx_r   <= tx_e - lx_e;
      dz_r   <= tz_e - lz_e;
      dy_r   <= rising ? (apex_e - ly_e) : (ty_e - apex_e);
      fx_r   <= liftoff_x;
      fz_r   <= liftoff_z;
      fy_r   <= rising ? ly_a : apex;
    end
  end

  assign t_xz    = t_xz_r;
  assign t_y     = t_y_r;
  assign delta_x = dx_r;
  assign delta_z = dz_r;
  assign delta_y = dy_r;
  assign from_x  = fx_r;
  assign from_z  = fz_r;
  assign from_y  = fy_r;
endmodule

// ===== src/fst_lane.sv =====
// one axis lane: smoothstep of the phase and scaled blend, stages 2 to 4
module fst_lane import fst_pkg::*; #(
  parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF,
  parameter int DELTA_WIDTH     = COORD_WIDTH_DEF + 1,
  parameter int FROM_WIDTH      = COORD_WIDTH_DEF
) (
  input  logic                           clk,
  input  pipe_en_t                       en,
  input  logic [PHASE_FRAC_BITS:0]       t,
  input  logic signed [DELTA_WIDTH-1:0]  delta,
  input  logic signed [FROM_WIDTH-1:0]   from,
  output logic signed [FROM_WIDTH-1:0]   result
);
  localparam int PF = PHASE_FRAC_BITS;
  localparam int DW = DELTA_WIDTH;
  localparam int FW = FROM_WIDTH;
  localparam int TW = PF + 1;
  localparam int WW = PF + 2;
  localparam int PW = DW + TW + 1;
  localparam logic [WW-1:0] ONE3 = WW'(3) << PF;

  logic [2*TW-1:0]      t2_w;
  logic [TW+WW-1:0]     sp_w;
  logic signed [TW:0]   s_se;
  logic signed [PW-1:0] sh_w;

  logic [TW-1:0]        t2_r;
  logic [WW-1:0]        w_r;
  logic signed [DW-1:0] d2_r;
  logic signed [FW-1:0] f2_r;
  logic [TW-1:0]        s_r;
  logic signed [DW-1:0] d3_r;
  logic signed [FW-1:0] f3_r;
  logic signed [PW-1:0] prod_r;
  logic signed [FW-1:0] f4_r;

  assign t2_w = (2*TW)'(t) * (2*TW)'(t);
  assign sp_w = (TW+WW)'(t2_r) * (TW+WW)'(w_r);
  assign s_se = {1'b0, s_r};

  always_ff @(posedge clk) begin
    if (en.s2) begin
      t2_r <= t2_w[PF+TW-1:PF];
      w_r  <= ONE3 - {t, 1'b0};
      d2_r <= delta;
      f2_r <= from;
    end
    if (en.s3) begin
      s_r  <= sp_w[PF+TW-1:PF];
      d3_r <= d2_r;
      f3_r <= f2_r;
    end
    if (en.s4) begin
      prod_r <= PW'(d3_r) * PW'(s_se);
      f4_r   <= f3_r;
    end
  end

  assign sh_w   = prod_r >>> PF;
  assign result = sh_w[FW-1:0] + f4_r;
endmodule

// ===== src/fst_merge.sv =====
// output register that gathers the three lane results into one item
module fst_merge import fst_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int APEX_WIDTH  = COORD_WIDTH_DEF + 1
) (
  input  logic                          clk,
  input  pipe_en_t                      en,
  input  logic signed [COORD_WIDTH-1:0] lane_x,
  input  logic signed [APEX_WIDTH-1:0]  lane_y,
  input  logic signed [COORD_WIDTH-1:0] lane_z,
  output logic signed [COORD_WIDTH-1:0] foot_x,
  output logic signed [COORD_WIDTH:0]   foot_y,
  output logic signed [COORD_WIDTH-1:0] foot_z
);
  logic signed [COORD_WIDTH-1:0] x_r, z_r;
  logic signed [COORD_WIDTH:0]   y_r;

  always_ff @(posedge clk) begin
    if (en.s5) begin
      x_r <= lane_x;
      y_r <= lane_y[COORD_WIDTH:0];
      z_r <= lane_z;
    end
  end

  assign foot_x = x_r;
  assign foot_y = y_r;
  assign foot_z = z_r;
endmodule

// ===== verif/foot_swing_trajectory_unit_tb.sv =====
// testbench for the foot swing trajectory unit: drives stride items and checks foot positions
module foot_swing_trajectory_unit_tb import fst_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = PHASE_FRAC_BITS_DEF;
  localparam int CW = COORD_WIDTH_DEF;
  localparam int PW = FRAC + 2;
  localparam longint ONE = longint'(1) << FRAC;
  localparam int CMAX = (1 << (CW - 1)) - 1;
  localparam int CMIN = -(1 << (CW - 1));
  localparam int PMAX = (1 << (PW - 1)) - 1;
  localparam int PMIN = -(1 << (PW - 1));
  localparam int HMAX = (1 << (STEP_WIDTH - 1)) - 1;
  localparam int HMIN = -(1 << (STEP_WIDTH - 1));
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT = 100000;

  typedef struct {
    logic signed [CW-1:0] lift_x;
    logic signed [CW-1:0] lift_y;
    logic signed [CW-1:0] lift_z;
    logic signed [CW-1:0] land_x;
    logic signed [CW-1:0] land_y;
    logic signed [CW-1:0] land_z;
    logic signed [PW-1:0] phase;
    logic signed [STEP_WIDTH-1:0] height;
  } stride_t;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW:0] y;
    logic signed [CW-1:0] z;
  } foot_t;

  logic clk;
  logic rst_n;
  int unsigned cycle_count = 0;
  int error_count = 0;
  int result_count = 0;
  bit idle_on = 1'b1;
  int hold_request = 0;
  foot_t expected_feet[$];

  fst_in_if #(.PHASE_FRAC_BITS(FRAC), .COORD_WIDTH(CW), .STEP_WIDTH(STEP_WIDTH)) in_ch ();
  fst_out_if #(.COORD_WIDTH(CW)) out_ch ();

  foot_swing_trajectory_unit #(.PHASE_FRAC_BITS(FRAC), .COORD_WIDTH(CW)) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint smoothstep_q(longint t);
    longint sq;
    sq = (t * t) >>> FRAC;
    return (sq * (3 * ONE - 2 * t)) >>> FRAC;
  endfunction

  function automatic longint ease(longint start_pt, longint end_pt, longint t);
    return start_pt + (((end_pt - start_pt) * smoothstep_q(t)) >>> FRAC);
  endfunction

  function automatic foot_t foot_position(stride_t s);
    longint ph;
    longint h;
    longint ly;
    longint ty;
    longint apex;
    foot_t f;
    ph = longint'(s.phase);
    if (ph < 0) ph = 0;
    if (ph > ONE) ph = ONE;
    h = longint'(s.height);
    if (h < 0) h = 0;
    ly = longint'(s.lift_y);
    ty = longint'(s.land_y);
    apex = ((ly > ty) ? ly : ty) + h;
    f.x = CW'(ease(longint'(s.lift_x), longint'(s.land_x), ph));
    f.z = CW'(ease(longint'(s.lift_z), longint'(s.land_z), ph));
    // rising half up to the apex, falling half down to touchdown
    if (ph < ONE / 2) begin
      f.y = (CW+1)'(ease(ly, apex, 2 * ph));
    end else begin
      f.y = (CW+1)'(ease(apex, ty, 2 * (ph - ONE / 2)));
    end
    return f;
  endfunction

  function automatic stride_t make_stride(int lx, int ly, int lz, int tx, int ty, int tz,
                                          int ph, int h);
    stride_t s;
    s.lift_x = CW'(lx);
    s.lift_y = CW'(ly);
    s.lift_z = CW'(lz);
    s.land_x = CW'(tx);
    s.land_y = CW'(ty);
    s.land_z = CW'(tz);
    s.phase = PW'(ph);
    s.height = STEP_WIDTH'(h);
    return s;
  endfunction

  function automatic stride_t random_stride();
    stride_t s;
    s.lift_x = CW'($urandom);
    s.lift_y = CW'($urandom);
    s.lift_z = CW'($urandom);
    s.land_x = CW'($urandom);
    s.land_y = CW'($urandom);
    s.land_z = CW'($urandom);
    case ($urandom_range(0, 9))
      0: s.phase = PW'($urandom);
      1: begin
        case ($urandom_range(0, 2))
          0: s.phase = PW'($urandom_range(0, 8));
          1: s.phase = PW'(ONE / 2 - 4 + $urandom_range(0, 8));
          default: s.phase = PW'(ONE - 8 + $urandom_range(0, 8));
        endcase
      end
      default: s.phase = PW'($urandom_range(0, ONE));
    endcase
    if ($urandom_range(0, 3) == 0) begin
      s.height = STEP_WIDTH'($urandom_range(0, 2048));
    end else begin
      s.height = STEP_WIDTH'($urandom);
    end
    return s;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s at result %0d: got %0d, expected %0d",
             what, result_count, got, want);
    error_count++;
  endtask

  task automatic send_stride(stride_t s);
    while (idle_on && $urandom_range(0, 99) < 12) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.liftoff_x <= s.lift_x;
    in_ch.liftoff_y <= s.lift_y;
    in_ch.liftoff_z <= s.lift_z;
    in_ch.touchdown_x <= s.land_x;
    in_ch.touchdown_y <= s.land_y;
    in_ch.touchdown_z <= s.land_z;
    in_ch.stride_phase <= s.phase;
    in_ch.step_height <= s.height;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    expected_feet.push_back(foot_position(s));
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_feet.size() != 0) @(posedge clk);
  endtask

  // result side stalls
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        out_ch.ready <= 1'b0;
        hold_request--;
      end else if (idle_on) begin
        out_ch.ready <= ($urandom_range(0, 99) >= 12);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // result checker
  initial begin
    foot_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (expected_feet.size() == 0) begin
          report_mismatch("unexpected item foot_x", out_ch.foot_x, 0);
        end else begin
          want = expected_feet.pop_front();
          if (out_ch.foot_x !== want.x) report_mismatch("foot_x", out_ch.foot_x, want.x);
          if (out_ch.foot_y !== want.y) report_mismatch("foot_y", out_ch.foot_y, want.y);
          if (out_ch.foot_z !== want.z) report_mismatch("foot_z", out_ch.foot_z, want.z);
        end
        result_count++;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("simulation failed");
    $finish;
  end

  task automatic test_phase_clamp();
    int phase_list[11];
    phase_list = '{PMIN, -1, 0, 1, 32767, 32768, 32769, 65535, 65536, 65537, PMAX};
    foreach (phase_list[i]) begin
      send_stride(make_stride(1000, -2000, 300, -5000, 7000, -900, phase_list[i], 512));
    end
  endtask

  task automatic test_coordinate_extremes();
    send_stride(make_stride(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 16384, HMAX));
    send_stride(make_stride(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 49152, HMAX));
    send_stride(make_stride(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 32768, HMAX));
    send_stride(make_stride(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 32767, 0));
    send_stride(make_stride(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, 40000, -1));
    send_stride(make_stride(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, 100, HMIN));
  endtask

  task automatic test_step_height();
    send_stride(make_stride(0, 5000, 0, 4000, -3000, 200, 32768, HMIN));
    send_stride(make_stride(0, -3000, 0, 4000, 5000, 200, 32768, -1));
    send_stride(make_stride(0, 2500, 0, 4000, 2500, 200, 32768, 0));
    send_stride(make_stride(0, 5000, 0, 4000, -3000, 200, 20000, 1));
    send_stride(make_stride(0, -3000, 0, 4000, 5000, 200, 20000, HMAX));
    send_stride(make_stride(0, 2500, 0, 4000, 2500, 200, 45000, 300));
  endtask

  task automatic test_random_strides(int count);
    repeat (count) send_stride(random_stride());
  endtask

  task automatic test_back_pressure();
    hold_request = 60;
    repeat (40) send_stride(random_stride());
    wait_drained();
  endtask

  task automatic test_drain_pause();
    repeat (25) send_stride(random_stride());
    wait_drained();
    repeat (25) send_stride(random_stride());
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    repeat (200) send_stride(random_stride());
    idle_on = 1'b1;
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.liftoff_x <= '0;
    in_ch.liftoff_y <= '0;
    in_ch.liftoff_z <= '0;
    in_ch.touchdown_x <= '0;
    in_ch.touchdown_y <= '0;
    in_ch.touchdown_z <= '0;
    in_ch.stride_phase <= '0;
    in_ch.step_height <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_phase_clamp();
    test_coordinate_extremes();
    test_step_height();
    test_random_strides(450);
    test_back_pressure();
    test_drain_pause();
    test_steady_stream();
    test_random_strides(480);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_feet.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
